@@ sv/wts_pkg.sv @@
// shared constants and types for the windowed turn smoother
// opcodes, configuration register indexes and the sequencer states
// no dependencies
`default_nettype none

package wts_pkg;

  localparam int MaxWindowDef = 16;

  localparam int AngleW   = 32;
  localparam int OpcodeW  = 2;
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 5;

  localparam logic [OpcodeW-1:0] OP_ADD   = 2'd0;
  localparam logic [OpcodeW-1:0] OP_RESET = 2'd1;
  localparam logic [OpcodeW-1:0] OP_QUERY = 2'd2;

  localparam logic [CfgIdxW-1:0] CFG_ENABLE = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_WINDOW = 1'd1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SUB_OLD,
    S_ADD_NEW,
    S_POS,
    S_ABS,
    S_DIV,
    S_NEG,
    S_ACC,
    S_DONE
  } state_e;

endpackage

`default_nettype wire

@@ sv/windowed_turn_smoother_unit.sv @@
// channel   dir  handshake                 payload
// in        in   in_valid_i / in_stall_o   opcode_i, turn_delta_i, start_angle_i, default_angle_i
// out       out  out_valid_o / out_stall_i view_angle_o
// cfg       in   cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// query, reset and disabled words give their result the cycle after acceptance.
// an add word runs the bit-serial restoring divider, one quotient bit per cycle,
// once for the position wrap and once for the average. one word is in flight at a time.
// reset clears ring valid bits at once, so there is no clearing pass.
// a pending result holds in the output register while out_stall_i is high.
// moving-average turn smoother, top level; depends on wts_pkg
`default_nettype none

module windowed_turn_smoother_unit
  import wts_pkg::*;
#(
  parameter int MAX_WINDOW = MaxWindowDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [OpcodeW-1:0]  opcode_i,
  input  wire logic signed [31:0]  turn_delta_i,
  input  wire logic [AngleW-1:0]   start_angle_i,
  input  wire logic [AngleW-1:0]   default_angle_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [AngleW-1:0]        view_angle_o,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  localparam int PTR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int PW1   = PTR_W + 1;
  localparam int WIN_W = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W = 33 + $clog2(MAX_WINDOW);
  localparam int CNT_W = $clog2(SUM_W + 1);

  state_e state_q, state_d;

  logic                enable_q;
  logic [CfgDataW-1:0] window_q;

  logic [31:0]      ring_mem [MAX_WINDOW];
  logic [31:0]      ring_rd_q;
  logic [MAX_WINDOW-1:0] ring_vld_q, ring_vld_d;
  logic             ring_we;

  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic [PTR_W-1:0]  pos_q, pos_d;
  logic [AngleW-1:0] angle_q, angle_d;
  logic [31:0]       delta_q, delta_d;
  logic              sign_q, sign_d;

  logic [SUM_W-1:0]  div_q, div_d;
  logic [WIN_W-1:0]  rem_q, rem_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;

  logic              out_valid_q, out_valid_d;
  logic [AngleW-1:0] view_q, view_d;

  logic              in_acc, out_free, out_load;
  logic [AngleW-1:0] out_value;
  logic [WIN_W-1:0]  win;
  logic [31:0]       old_delta;
  logic [PW1-1:0]    pos_inc;

  // shared adder
  logic [SUM_W-1:0]  add_a, add_b, add_res;
  logic              add_sub;

  // divider step
  logic [WIN_W:0]    trial, trial_diff;
  logic              trial_ge;
  logic [WIN_W-1:0]  rem_step;
  logic [SUM_W-1:0]  div_step;

  assign cfg_ready_o  = 1'b1;
  assign out_valid_o  = out_valid_q;
  assign view_angle_o = view_q;
  assign out_free     = !out_valid_q || !out_stall_i;
  assign in_stall_o   = (state_q != S_IDLE) || !out_free;
  assign in_acc       = in_valid_i && !in_stall_o;

  // effective window: zero acts as one, clamp to the ring depth
  always_comb begin
    if (window_q == '0) begin
      win = WIN_W'(1);
    end else if ({27'd0, window_q} > 32'(MAX_WINDOW)) begin
      win = WIN_W'(MAX_WINDOW);
    end else begin
      win = WIN_W'(window_q);
    end
  end

  assign old_delta = ring_vld_q[pos_q] ? ring_rd_q : 32'd0;
  assign pos_inc   = {1'b0, pos_q} + PW1'(1);

  assign add_res = add_a + (add_sub ? ~add_b : add_b) + SUM_W'(add_sub);

  assign trial      = {rem_q, div_q[SUM_W-1]};
  assign trial_ge   = trial >= {1'b0, win};
  assign trial_diff = trial - {1'b0, win};
  assign rem_step   = trial_ge ? trial_diff[WIN_W-1:0] : trial[WIN_W-1:0];
  assign div_step   = {div_q[SUM_W-2:0], trial_ge};

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc && enable_q && opcode_i == OP_ADD) state_d = S_SUB_OLD;
      end
      S_SUB_OLD: state_d = S_ADD_NEW;
      S_ADD_NEW: state_d = S_POS;
      S_POS: begin
        if (cnt_q == CNT_W'(1)) state_d = S_ABS;
      end
      S_ABS: state_d = S_DIV;
      S_DIV: begin
        if (cnt_q == CNT_W'(1)) state_d = S_NEG;
      end
      S_NEG: state_d = S_ACC;
      S_ACC: state_d = S_DONE;
      S_DONE: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    sum_d      = sum_q;
    pos_d      = pos_q;
    angle_d    = angle_q;
    delta_d    = delta_q;
    sign_d     = sign_q;
    div_d      = div_q;
    rem_d      = rem_q;
    cnt_d      = cnt_q;
    ring_vld_d = ring_vld_q;
    ring_we    = 1'b0;
    add_a      = sum_q;
    add_b      = '0;
    add_sub    = 1'b0;
    out_load   = 1'b0;
    out_value  = angle_q;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (!enable_q) begin
            out_load  = 1'b1;
            out_value = default_angle_i;
          end else begin
            case (opcode_i)
              OP_ADD: begin
                delta_d = turn_delta_i;
              end
              OP_RESET: begin
                angle_d    = start_angle_i;
                sum_d      = '0;
                pos_d      = '0;
                ring_vld_d = '0;
                out_load   = 1'b1;
                out_value  = start_angle_i;
              end
              default: begin
                // query and the unused code leave state alone
                out_load  = 1'b1;
                out_value = angle_q;
              end
            endcase
          end
        end
      end
      S_SUB_OLD: begin
        add_a   = sum_q;
        add_b   = {{(SUM_W-32){old_delta[31]}}, old_delta};
        add_sub = 1'b1;
        sum_d   = add_res;
      end
      S_ADD_NEW: begin
        add_a   = sum_q;
        add_b   = {{(SUM_W-32){delta_q[31]}}, delta_q};
        sum_d   = add_res;
        ring_we = 1'b1;
        ring_vld_d[pos_q] = 1'b1;
        // pos + 1 aligned to the top so only PW1 steps are needed
        div_d = {pos_inc, {(SUM_W-PW1){1'b0}}};
        rem_d = '0;
        cnt_d = CNT_W'(PW1);
      end
      S_POS: begin
        div_d = div_step;
        rem_d = rem_step;
        cnt_d = cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) pos_d = rem_step[PTR_W-1:0];
      end
      S_ABS: begin
        add_a   = '0;
        add_b   = sum_q;
        add_sub = sum_q[SUM_W-1];
        sign_d  = sum_q[SUM_W-1];
        div_d   = add_res;
        rem_d   = '0;
        cnt_d   = CNT_W'(SUM_W);
      end
      S_DIV: begin
        div_d = div_step;
        rem_d = rem_step;
        cnt_d = cnt_q - CNT_W'(1);
      end
      S_NEG: begin
        // quotient truncates toward zero: negate the magnitude back
        add_a   = '0;
        add_b   = div_q;
        add_sub = sign_q;
        div_d   = add_res;
      end
      S_ACC: begin
        add_a   = {{(SUM_W-32){1'b0}}, angle_q};
        add_b   = div_q;
        angle_d = add_res[AngleW-1:0];
      end
      S_DONE: begin
        if (out_free) begin
          out_load  = 1'b1;
          out_value = angle_q;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    view_d      = view_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      view_d      = out_value;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      enable_q    <= 1'b0;
      window_q    <= CfgDataW'(6);
      ring_vld_q  <= '0;
      sum_q       <= '0;
      pos_q       <= '0;
      angle_q     <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ring_vld_q  <= ring_vld_d;
      sum_q       <= sum_d;
      pos_q       <= pos_d;
      angle_q     <= angle_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_ENABLE: enable_q <= cfg_data_i[0];
          CFG_WINDOW: window_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    delta_q <= delta_d;
    sign_q  <= sign_d;
    div_q   <= div_d;
    rem_q   <= rem_d;
    view_q  <= view_d;
  end

  // delta ring, registered read at the write position
  always_ff @(posedge clk_i) begin
    if (ring_we) ring_mem[pos_q] <= delta_q;
    ring_rd_q <= ring_mem[pos_q];
  end

`ifndef SYNTHESIS
  a_rem_below_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV || state_q == S_POS) |-> (rem_q < win))
    else $error("divider remainder not below window");

  a_pos_in_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {{(32-PTR_W){1'b0}}, pos_q} < 32'(MAX_WINDOW))
    else $error("write position beyond ring depth");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(in_acc) || $past(state_q == S_DONE)))
    else $error("result appeared without a word to finish");

  a_busy_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE && state_q != S_DONE) |=> !out_load || state_q == S_DONE
      || state_q == S_IDLE)
    else $error("result loaded while add word in progress");
`endif

endmodule

`default_nettype wire
